// ----- src/hrc_pkg.sv -----
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared constants, types and arithmetic helpers of the HSV/RGB converter.
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int CHANNEL_BITS = 16;
    localparam logic [CHANNEL_BITS-1:0] FS = '1;

    localparam logic MODE_HSV2RGB = 1'b0;
    localparam logic MODE_RGB2HSV = 1'b1;

    localparam logic [1:0] MAX_RED   = 2'd0;
    localparam logic [1:0] MAX_GREEN = 2'd1;
    localparam logic [1:0] MAX_BLUE  = 2'd2;

    // divider: quotient bits, denominator bits, numerator bits
    localparam int DIV_QW = 17;
    localparam int DIV_DW = 19;
    localparam int DIV_NW = DIV_DW + DIV_QW - 1;

    localparam int LATENCY  = 20;
    localparam int HSV_DLY  = 15;
    localparam int SIDE_DLY = 18;

    typedef struct packed {
        logic        mode;
        logic [15:0] alpha;
        logic [15:0] mx;
        logic        grey;
    } t_side;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } t_rgb;

    // (x + FS/2) / FS, x below 2^33
    function automatic logic [15:0] mul_fs(input logic [32:0] x);
        logic [33:0] y;
        logic [17:0] q0;
        logic [18:0] t;
        logic [18:0] q;
        y  = {1'b0, x} + 34'd32767;
        q0 = y[33:16];
        t  = {1'b0, q0} + {3'b0, y[15:0]};
        q  = {1'b0, q0} + {18'b0, (t >= 19'd65535)} + {18'b0, (t >= 19'd131070)};
        return q[15:0];
    endfunction

endpackage

// ----- src/hrc_div.sv -----
// ----------------------------------------------------------------------------
// hrc_div
// Pipelined restoring divider, one quotient bit per stage, fixed latency.
// ----------------------------------------------------------------------------
module hrc_div (
    input  logic                          i_clk,
    input  logic [hrc_pkg::DIV_NW-1:0]    i_num,
    input  logic [hrc_pkg::DIV_DW-1:0]    i_den,
    output logic [hrc_pkg::DIV_QW-1:0]    o_quo
);

    localparam int QW = hrc_pkg::DIV_QW;
    localparam int DW = hrc_pkg::DIV_DW;
    localparam int NW = hrc_pkg::DIV_NW;

    logic [NW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];
    logic [NW-1:0] n_rem [0:QW-1];
    logic [QW-1:0] n_quo [0:QW-1];

    always_comb begin
        logic [NW-1:0] s_rem;
        logic [DW-1:0] s_den;
        logic [QW-1:0] s_quo;
        logic [NW-1:0] dsh;
        for (int j = 0; j < QW; j++) begin
            if (j == 0) begin
                s_rem = i_num;
                s_den = i_den;
                s_quo = '0;
            end else begin
                s_rem = r_rem[j-1];
                s_den = r_den[j-1];
                s_quo = r_quo[j-1];
            end
            dsh = {{(QW-1){1'b0}}, s_den} << (QW-1-j);
            if (s_rem >= dsh) begin
                n_rem[j] = s_rem - dsh;
                n_quo[j] = s_quo | (QW'(1) << (QW-1-j));
            end else begin
                n_rem[j] = s_rem;
                n_quo[j] = s_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_den[0] <= i_den;
        for (int j = 1; j < QW; j++) begin
            r_den[j] <= r_den[j-1];
        end
        for (int j = 0; j < QW; j++) begin
            r_rem[j] <= n_rem[j];
            r_quo[j] <= n_quo[j];
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ----- src/hsv_rgb_converter_unit.sv -----
// ----------------------------------------------------------------------------
// hsv_rgb_converter_unit
// Converts one color per transaction between HSV and RGB, Q0.16 channels.
//
// Input: a transaction is taken on a rising edge with i_start high and
// o_busy low. o_busy is low whenever reset is released, so a new color can
// enter on every clock. i_mode selects HSV to RGB (0) or RGB to HSV (1).
// Output: each result shows for one cycle with o_valid high, in input order.
// The receiver cannot stall the block.
// Throughput is one color per clock; the latency is set by the 17-stage
// divider that forms saturation and hue in RGB to HSV mode, and the HSV to
// RGB path is delayed to match it.
// Reset (synchronous, active low) empties the pipeline; results in flight
// are dropped and o_busy is high while reset is held.
// Alpha is copied to the output unchanged.
// ----------------------------------------------------------------------------
module hsv_rgb_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_mode,
    input  logic [15:0] i_hue_or_red,
    input  logic [15:0] i_sat_or_green,
    input  logic [15:0] i_val_or_blue,
    input  logic [15:0] i_alpha_in,
    output logic        o_busy,
    output logic        o_valid,
    output logic [15:0] o_red_or_hue,
    output logic [15:0] o_green_or_sat,
    output logic [15:0] o_blue_or_val,
    output logic [15:0] o_alpha_out
);

    localparam int LAT = hrc_pkg::LATENCY;

    logic [LAT-1:0] r_vld;

    // stage A
    logic [18:0] a_h6;
    logic [1:0]  a_msel;
    logic [15:0] a_mx, a_mn;
    logic        r_a_mode;
    logic [15:0] r_a_alpha, r_a_c0, r_a_c1, r_a_c2, r_a_f, r_a_mx, r_a_d;
    logic [2:0]  r_a_sec;
    logic [1:0]  r_a_msel;

    // stage B
    logic signed [20:0] b_n;
    logic [18:0] b_un;
    logic [2:0]  r_b_sec;
    logic [15:0] r_b_v;
    logic        r_b_sz;
    logic [31:0] r_b_psf, r_b_pp;
    logic [32:0] r_b_psfc;
    logic [hrc_pkg::DIV_NW-1:0] r_b_hnum, r_b_snum;
    logic [hrc_pkg::DIV_DW-1:0] r_b_hden, r_b_sden;

    // stage C, D
    logic [32:0] c_sf_sum;
    logic [33:0] c_sfc_sum;
    logic [2:0]  r_c_sec, r_d_sec;
    logic [15:0] r_c_v, r_c_sf, r_c_sfc, r_c_p, r_d_v, r_d_p;
    logic        r_c_sz, r_d_sz;
    logic [31:0] r_d_pq, r_d_pt;

    // stage E and delay lines
    hrc_pkg::t_rgb  e_rgb;
    logic [15:0]    e_q, e_t;
    hrc_pkg::t_rgb  r_hl [0:hrc_pkg::HSV_DLY-1];
    hrc_pkg::t_side r_sd [0:hrc_pkg::SIDE_DLY-1];
    hrc_pkg::t_side sd;

    logic [hrc_pkg::DIV_QW-1:0] q_h, q_s;
    logic [15:0] r_o_r, r_o_g, r_o_b, r_o_a;
    logic [15:0] n_o_r, n_o_g, n_o_b;

    assign o_busy = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    always_comb begin
        a_h6 = {3'b0, i_hue_or_red} * 19'd6;
        if (i_hue_or_red >= i_sat_or_green && i_hue_or_red >= i_val_or_blue) begin
            a_msel = hrc_pkg::MAX_RED;
            a_mx   = i_hue_or_red;
        end else if (i_sat_or_green >= i_val_or_blue) begin
            a_msel = hrc_pkg::MAX_GREEN;
            a_mx   = i_sat_or_green;
        end else begin
            a_msel = hrc_pkg::MAX_BLUE;
            a_mx   = i_val_or_blue;
        end
        a_mn = (i_hue_or_red <= i_sat_or_green) ? i_hue_or_red : i_sat_or_green;
        a_mn = (a_mn <= i_val_or_blue) ? a_mn : i_val_or_blue;
    end

    always_ff @(posedge i_clk) begin
        r_a_mode  <= i_mode;
        r_a_alpha <= i_alpha_in;
        r_a_c0    <= i_hue_or_red;
        r_a_c1    <= i_sat_or_green;
        r_a_c2    <= i_val_or_blue;
        r_a_sec   <= a_h6[18:16];
        r_a_f     <= a_h6[15:0];
        r_a_msel  <= a_msel;
        r_a_mx    <= a_mx;
        r_a_d     <= a_mx - a_mn;
    end

    always_comb begin
        case (r_a_msel)
            hrc_pkg::MAX_RED: begin
                b_n = $signed({5'b0, r_a_c1}) - $signed({5'b0, r_a_c2});
            end
            hrc_pkg::MAX_GREEN: begin
                b_n = $signed({4'b0, r_a_d, 1'b0}) + $signed({5'b0, r_a_c2})
                    - $signed({5'b0, r_a_c0});
            end
            default: begin
                b_n = $signed({3'b0, r_a_d, 2'b0}) + $signed({5'b0, r_a_c0})
                    - $signed({5'b0, r_a_c1});
            end
        endcase
        if (b_n < 0) begin
            b_n = b_n + $signed({5'b0, r_a_d} * 21'd6);
        end
        b_un = b_n[18:0];
    end

    always_ff @(posedge i_clk) begin
        r_b_sec  <= r_a_sec;
        r_b_v    <= r_a_c2;
        r_b_sz   <= (r_a_c1 == '0);
        r_b_psf  <= 32'(r_a_c1) * 32'(r_a_f);
        r_b_psfc <= 33'({1'b0, r_a_c1}) * 33'(17'h10000 - {1'b0, r_a_f});
        r_b_pp   <= 32'(r_a_c2) * 32'(hrc_pkg::FS - r_a_c1);
        r_b_hnum <= {b_un, 16'b0} + {17'b0, ({2'b0, r_a_d} * 18'd3)};
        r_b_hden <= {3'b0, r_a_d} * 19'd6;
        r_b_snum <= {3'b0, ({r_a_d, 16'b0} - {16'b0, r_a_d})}
                  + {20'b0, r_a_mx[15:1]};
        r_b_sden <= {3'b0, r_a_mx};
    end

    hrc_div u_div_hue (
        .i_clk (i_clk),
        .i_num (r_b_hnum),
        .i_den (r_b_hden),
        .o_quo (q_h)
    );

    hrc_div u_div_sat (
        .i_clk (i_clk),
        .i_num (r_b_snum),
        .i_den (r_b_sden),
        .o_quo (q_s)
    );

    assign c_sf_sum  = {1'b0, r_b_psf} + 33'd32768;
    assign c_sfc_sum = {1'b0, r_b_psfc} + 34'd32768;

    always_ff @(posedge i_clk) begin
        r_c_sec <= r_b_sec;
        r_c_v   <= r_b_v;
        r_c_sz  <= r_b_sz;
        r_c_sf  <= c_sf_sum[31:16];
        r_c_sfc <= c_sfc_sum[31:16];
        r_c_p   <= hrc_pkg::mul_fs({1'b0, r_b_pp});
    end

    always_ff @(posedge i_clk) begin
        r_d_sec <= r_c_sec;
        r_d_v   <= r_c_v;
        r_d_sz  <= r_c_sz;
        r_d_p   <= r_c_p;
        r_d_pq  <= 32'(r_c_v) * 32'(hrc_pkg::FS - r_c_sf);
        r_d_pt  <= 32'(r_c_v) * 32'(hrc_pkg::FS - r_c_sfc);
    end

    always_comb begin
        e_q = hrc_pkg::mul_fs({1'b0, r_d_pq});
        e_t = hrc_pkg::mul_fs({1'b0, r_d_pt});
        case (r_d_sec)
            3'd0:    e_rgb = '{r: r_d_v, g: e_t,   b: r_d_p};
            3'd1:    e_rgb = '{r: e_q,   g: r_d_v, b: r_d_p};
            3'd2:    e_rgb = '{r: r_d_p, g: r_d_v, b: e_t};
            3'd3:    e_rgb = '{r: r_d_p, g: e_q,   b: r_d_v};
            3'd4:    e_rgb = '{r: e_t,   g: r_d_p, b: r_d_v};
            default: e_rgb = '{r: r_d_v, g: r_d_p, b: e_q};
        endcase
        if (r_d_sz) begin
            e_rgb = '{r: r_d_v, g: r_d_v, b: r_d_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r_hl[0] <= e_rgb;
        for (int k = 1; k < hrc_pkg::HSV_DLY; k++) begin
            r_hl[k] <= r_hl[k-1];
        end
        r_sd[0] <= '{mode: r_a_mode, alpha: r_a_alpha, mx: r_a_mx, grey: (r_a_d == '0)};
        for (int k = 1; k < hrc_pkg::SIDE_DLY; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    assign sd = r_sd[hrc_pkg::SIDE_DLY-1];

    always_comb begin
        if (sd.mode == hrc_pkg::MODE_RGB2HSV) begin
            n_o_r = sd.grey ? '0 : q_h[15:0];
            n_o_g = sd.grey ? '0 : q_s[15:0];
            n_o_b = sd.mx;
        end else begin
            n_o_r = r_hl[hrc_pkg::HSV_DLY-1].r;
            n_o_g = r_hl[hrc_pkg::HSV_DLY-1].g;
            n_o_b = r_hl[hrc_pkg::HSV_DLY-1].b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_r <= n_o_r;
        r_o_g <= n_o_g;
        r_o_b <= n_o_b;
        r_o_a <= sd.alpha;
    end

    assign o_valid        = r_vld[LAT-1];
    assign o_red_or_hue   = r_o_r;
    assign o_green_or_sat = r_o_g;
    assign o_blue_or_val  = r_o_b;
    assign o_alpha_out    = r_o_a;

endmodule

// ----- src/hrc_chk.sv -----
// ----------------------------------------------------------------------------
// hrc_chk
// Port-level checks of the HSV/RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hrc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        i_mode,
    input logic [15:0] i_hue_or_red,
    input logic [15:0] i_sat_or_green,
    input logic [15:0] i_val_or_blue,
    input logic [15:0] i_alpha_in,
    input logic        o_busy,
    input logic        o_valid,
    input logic [15:0] o_red_or_hue,
    input logic [15:0] o_green_or_sat,
    input logic [15:0] o_blue_or_val,
    input logic [15:0] o_alpha_out
);

    a_no_busy: assert property (@(posedge i_clk) i_rst_n |-> !o_busy)
        else $error("busy while out of reset");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, hrc_pkg::LATENCY))
        else $error("result without transaction");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_alpha_out == $past(i_alpha_in, hrc_pkg::LATENCY))
        else $error("alpha mismatch");

    a_val_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_mode, hrc_pkg::LATENCY) == hrc_pkg::MODE_RGB2HSV |->
        o_blue_or_val >= $past(i_hue_or_red, hrc_pkg::LATENCY) &&
        o_blue_or_val >= $past(i_sat_or_green, hrc_pkg::LATENCY) &&
        o_blue_or_val >= $past(i_val_or_blue, hrc_pkg::LATENCY))
        else $error("value is not the channel maximum");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_mode, hrc_pkg::LATENCY) == hrc_pkg::MODE_HSV2RGB &&
        $past(i_sat_or_green, hrc_pkg::LATENCY) == 16'd0 |->
        o_red_or_hue == $past(i_val_or_blue, hrc_pkg::LATENCY) &&
        o_green_or_sat == $past(i_val_or_blue, hrc_pkg::LATENCY) &&
        o_blue_or_val == $past(i_val_or_blue, hrc_pkg::LATENCY))
        else $error("zero saturation is not grey");

endmodule

bind hsv_rgb_converter_unit hrc_chk u_hrc_chk (.*);

// ----- sim/hsv_rgb_converter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// hsv_rgb_converter_unit_tb
// Self-checking bench for the HSV/RGB converter: a directed table of colors
// followed by random bursts, each result checked against table or local model.
// ----------------------------------------------------------------------------
module hsv_rgb_converter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        mode;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] alpha;
    } t_color_in;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] alpha;
    } t_color_out;

    typedef struct {
        t_color_in  stim;
        bit         known;
        t_color_out res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_mode = hrc_pkg::MODE_HSV2RGB;
    logic [15:0] i_hue_or_red = '0;
    logic [15:0] i_sat_or_green = '0;
    logic [15:0] i_val_or_blue = '0;
    logic [15:0] i_alpha_in = '0;
    logic        o_busy;
    logic        o_valid;
    logic [15:0] o_red_or_hue;
    logic [15:0] o_green_or_sat;
    logic [15:0] o_blue_or_val;
    logic [15:0] o_alpha_out;

    t_color_out pending_colors[$];
    int         err_cnt = 0;

    always #5 i_clk = ~i_clk;

    hsv_rgb_converter_unit u_top (.*);

    function automatic longint unsigned fs_mul(longint unsigned a, longint unsigned b);
        return (a * b + 32767) / 65535;
    endfunction

    function automatic t_color_out convert_color(t_color_in c);
        t_color_out     o;
        longint unsigned h6, sec, f, sf, sfc, p, q, t, mx, mn, d, s, hue;
        longint         n;
        o.alpha = c.alpha;
        if (c.mode == hrc_pkg::MODE_HSV2RGB) begin
            if (c.b == 0) begin
                o.x = c.c; o.y = c.c; o.z = c.c;
                return o;
            end
            h6  = longint'(c.a) * 6;
            sec = h6 >> 16;
            f   = h6 & 65535;
            sf  = (c.b * f + 32768) >> 16;
            sfc = (c.b * (65536 - f) + 32768) >> 16;
            p   = fs_mul(c.c, 65535 - c.b);
            q   = fs_mul(c.c, 65535 - sf);
            t   = fs_mul(c.c, 65535 - sfc);
            case (sec)
                0: begin o.x = c.c;     o.y = 16'(t); o.z = 16'(p); end
                1: begin o.x = 16'(q);  o.y = c.c;    o.z = 16'(p); end
                2: begin o.x = 16'(p);  o.y = c.c;    o.z = 16'(t); end
                3: begin o.x = 16'(p);  o.y = 16'(q); o.z = c.c;    end
                4: begin o.x = 16'(t);  o.y = 16'(p); o.z = c.c;    end
                default: begin o.x = c.c; o.y = 16'(p); o.z = 16'(q); end
            endcase
        end else begin
            mx = (c.a > c.b) ? c.a : c.b;
            mx = (mx > c.c) ? mx : c.c;
            mn = (c.a < c.b) ? c.a : c.b;
            mn = (mn < c.c) ? mn : c.c;
            d  = mx - mn;
            s  = (mx != 0) ? (d * 65535 + (mx >> 1)) / mx : 0;
            o.z = 16'(mx);
            o.y = 16'(s);
            o.x = '0;
            if (s == 0 || d == 0) begin
                o.y = '0;
                return o;
            end
            if (c.a == mx)      n = longint'(c.b) - longint'(c.c);
            else if (c.b == mx) n = 2 * longint'(d) + c.c - c.a;
            else                n = 4 * longint'(d) + c.a - c.b;
            if (n < 0) n += 6 * longint'(d);
            hue = (longint'(n) * 65536 + 3 * d) / (6 * d);
            o.x = hue[15:0];
        end
        return o;
    endfunction

    task automatic send_color(t_color_in c, bit known, t_color_out res);
        i_start        <= 1'b1;
        i_mode         <= c.mode;
        i_hue_or_red   <= c.a;
        i_sat_or_green <= c.b;
        i_val_or_blue  <= c.c;
        i_alpha_in     <= c.alpha;
        do @(posedge i_clk); while (o_busy);
        pending_colors.push_back(known ? res : convert_color(c));
    endtask

    task automatic idle_cycles(int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_color_out exp_c;
        if (i_rst_n && o_valid) begin
            if (pending_colors.size() == 0) begin
                $error("unexpected transaction");
                err_cnt++;
            end else begin
                exp_c = pending_colors.pop_front();
                if (o_red_or_hue !== exp_c.x) begin
                    $error("red_or_hue exp %0d got %0d", exp_c.x, o_red_or_hue);
                    err_cnt++;
                end
                if (o_green_or_sat !== exp_c.y) begin
                    $error("green_or_sat exp %0d got %0d", exp_c.y, o_green_or_sat);
                    err_cnt++;
                end
                if (o_blue_or_val !== exp_c.z) begin
                    $error("blue_or_val exp %0d got %0d", exp_c.z, o_blue_or_val);
                    err_cnt++;
                end
                if (o_alpha_out !== exp_c.alpha) begin
                    $error("alpha_out exp %0d got %0d", exp_c.alpha, o_alpha_out);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_row       rows[$];
        t_color_in  c;
        t_color_out none;
        int         burst, k, m;
        none = '0;
        // grey, black, white, sectors, ties, negative hue wrap
        rows = '{
            '{'{hrc_pkg::MODE_HSV2RGB, 16'd0,     16'd0,     16'd0,     16'd0},     1,
              '{16'd0, 16'd0, 16'd0, 16'd0}},
            '{'{hrc_pkg::MODE_HSV2RGB, 16'hffff,  16'd0,     16'hffff,  16'hffff},  1,
              '{16'hffff, 16'hffff, 16'hffff, 16'hffff}},
            '{'{hrc_pkg::MODE_HSV2RGB, 16'd0,     16'hffff,  16'hffff,  16'h1234},  1,
              '{16'hffff, 16'd0, 16'd0, 16'h1234}},
            '{'{hrc_pkg::MODE_HSV2RGB, 16'd10923, 16'hffff,  16'hffff,  16'd0}, 0, none},
            '{'{hrc_pkg::MODE_HSV2RGB, 16'd21846, 16'hffff,  16'h8000,  16'd0}, 0, none},
            '{'{hrc_pkg::MODE_HSV2RGB, 16'd32768, 16'h8000,  16'hffff,  16'd0}, 0, none},
            '{'{hrc_pkg::MODE_HSV2RGB, 16'd43691, 16'h0001,  16'hffff,  16'd0}, 0, none},
            '{'{hrc_pkg::MODE_HSV2RGB, 16'd54614, 16'hffff,  16'h0001,  16'd0}, 0, none},
            '{'{hrc_pkg::MODE_HSV2RGB, 16'hffff,  16'hffff,  16'hffff,  16'd0}, 0, none},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'd0,     16'd0,     16'd0,     16'h5555},  1,
              '{16'd0, 16'd0, 16'd0, 16'h5555}},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'h7777,  16'h7777,  16'h7777,  16'hffff},  1,
              '{16'd0, 16'd0, 16'h7777, 16'hffff}},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'hffff,  16'd0,     16'd0,     16'd0},     1,
              '{16'd0, 16'hffff, 16'hffff, 16'd0}},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'hffff,  16'hffff,  16'd0,     16'd0}, 0, none},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'd0,     16'hffff,  16'hffff,  16'd0}, 0, none},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'hffff,  16'd0,     16'hffff,  16'd0}, 0, none},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'hffff,  16'd0,     16'd1,     16'd0}, 0, none},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'd0,     16'hffff,  16'd0,     16'd0}, 0, none},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'd0,     16'd0,     16'hffff,  16'd0}, 0, none},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'd1,     16'd0,     16'd0,     16'd0}, 0, none},
            '{'{hrc_pkg::MODE_RGB2HSV, 16'hffff,  16'hfffe,  16'hffff,  16'd0}, 0, none}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) send_color(rows[i].stim, rows[i].known, rows[i].res);
        idle_cycles(3);
        for (k = 0; k < 1750; ) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) burst = 1;
            for (m = 0; m < burst && k < 1750 && (m == 0 || k != 800); m++, k++) begin
                c.mode  = 1'($urandom_range(0, 1));
                c.a     = 16'($urandom);
                c.b     = 16'($urandom);
                c.c     = 16'($urandom);
                c.alpha = 16'($urandom);
                case ($urandom_range(0, 9))
                    0: c.b = (c.mode == hrc_pkg::MODE_HSV2RGB) ? 16'd0 : c.a;
                    1: c.c = c.a;
                    2: c.a = 16'($urandom_range(0, 3));
                    3: begin c.a = c.a >> 12; c.b = c.b >> 12; c.c = c.c >> 12; end
                    default: ;
                endcase
                send_color(c, 0, none);
            end
            if (k == 800) begin
                i_start <= 1'b0;
                while (pending_colors.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 2) != 0) begin
                idle_cycles($urandom_range(1, 25));
            end
        end
        i_start <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (hrc_pkg::LATENCY + 10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
